// File: rtl/core/datalog_lexer_top_macros.svh
// Assertion macros shared by the lexer checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef DATALOG_LEXER_TOP_MACROS_SVH
`define DATALOG_LEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dlx_pkg.sv
// Package for the Datalog lexer: token kinds, lexer modes, character codes
// and keyword tables. No dependencies.
`default_nettype none

package dlx_pkg;

	typedef enum logic [4:0] {
		TK_COMMA      = 5'd0,
		TK_PERIOD     = 5'd1,
		TK_Q_MARK     = 5'd2,
		TK_LPAREN     = 5'd3,
		TK_RPAREN     = 5'd4,
		TK_COLON      = 5'd5,
		TK_COLON_DASH = 5'd6,
		TK_MULTIPLY   = 5'd7,
		TK_ADD        = 5'd8,
		TK_SCHEMES    = 5'd9,
		TK_FACTS      = 5'd10,
		TK_RULES      = 5'd11,
		TK_QUERIES    = 5'd12,
		TK_ID         = 5'd13,
		TK_STRING     = 5'd14,
		TK_COMMENT    = 5'd15,
		TK_UNDEFINED  = 5'd16,
		TK_EOF        = 5'd17
	} token_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'd0,
		MODE_COLON = 4'd1,
		MODE_ID    = 4'd2,
		MODE_STR   = 4'd3,
		MODE_STRQ  = 4'd4,
		MODE_HASH  = 4'd5,
		MODE_LINE  = 4'd6,
		MODE_BLOCK = 4'd7,
		MODE_BAR   = 4'd8
	} lex_mode_t;

	// keyword candidates, chosen by the first letter
	typedef enum logic [1:0] {
		KW_SCHEMES = 2'd0,
		KW_FACTS   = 2'd1,
		KW_RULES   = 2'd2,
		KW_QUERIES = 2'd3
	} kw_cand_t;

	localparam int OUT_BITS = 16;   // width of line and length fields on the ports

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = 2;
	localparam int CNT_BITS   = 3;

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_UC_S   = 8'h53;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_R   = 8'h52;
	localparam logic [7:0] CH_UC_Q   = 8'h51;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	function automatic logic is_alpha(input logic [7:0] b);
		logic [7:0] l;
		l = b | CASE_BIT;
		return (l >= CH_LC_A) && (l <= CH_LC_Z);
	endfunction

	function automatic logic is_idchar(input logic [7:0] b);
		return is_alpha(b) || ((b >= CH_DIG_0) && (b <= CH_DIG_9)) || (b == CH_UNDER);
	endfunction

	function automatic logic [2:0] kw_len(input kw_cand_t c);
		logic [2:0] r;
		unique case (c)
			KW_SCHEMES: r = 3'd7;
			KW_FACTS:   r = 3'd5;
			KW_RULES:   r = 3'd5;
			KW_QUERIES: r = 3'd7;
			default:    r = 3'd0;
		endcase
		return r;
	endfunction

	// byte at position pos of the keyword, first letter at position zero
	function automatic logic [7:0] kw_char(input kw_cand_t c, input logic [2:0] pos);
		logic [63:0] w;
		unique case (c)
			KW_SCHEMES: w = {"Schemes", 8'h00};
			KW_FACTS:   w = {"Facts", 24'h000000};
			KW_RULES:   w = {"Rules", 24'h000000};
			KW_QUERIES: w = {"Queries", 8'h00};
			default:    w = '0;
		endcase
		return w[{~pos, 3'b000} +: 8];
	endfunction

	function automatic token_kind_t kw_token(input kw_cand_t c);
		token_kind_t k;
		unique case (c)
			KW_SCHEMES: k = TK_SCHEMES;
			KW_FACTS:   k = TK_FACTS;
			KW_RULES:   k = TK_RULES;
			KW_QUERIES: k = TK_QUERIES;
			default:    k = TK_ID;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/datalog_lexer_top.sv
// Datalog lexer top level: input register, lexer state machine, token queue.
// Depends on dlx_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_stall  | in_byte, is_end
//   output  | out_valid / out_stall| token_kind, token_line, token_length, last
//
// One byte a cycle while the input register is not held; beats are lexed from it.
// A beat gives zero, one or two tokens; they go into a four-entry queue, which
// drains one token a cycle unless the output stalls. The input register is held
// while fewer than two entries are free, so two-token bursts run at the output rate.
// Reset: lexer idle at line one, queue empty. The end mark also returns the
// lexer to that state after its EOF token.
`default_nettype none

module datalog_lexer_top #(
	parameter int LINE_BITS   = 16,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [7:0]                   in_byte,
	input  wire logic                         is_end,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [4:0]                   token_kind,
	output      logic [dlx_pkg::OUT_BITS-1:0] token_line,
	output      logic [dlx_pkg::OUT_BITS-1:0] token_length,
	output      logic                         last
);

	// counters saturate at the narrower of the parameter and the port width
	localparam int LW = (LINE_BITS < dlx_pkg::OUT_BITS) ? LINE_BITS : dlx_pkg::OUT_BITS;
	localparam int NW = (LENGTH_BITS < dlx_pkg::OUT_BITS) ? LENGTH_BITS : dlx_pkg::OUT_BITS;
	localparam logic [LW-1:0] LINE_MAX = {LW{1'b1}};
	localparam logic [NW-1:0] LEN_MAX  = {NW{1'b1}};

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       take;

	// lexer state
	dlx_pkg::lex_mode_t mode_q, mode_d;
	logic [LW-1:0]      cur_line_q, cur_line_d;
	logic [LW-1:0]      start_line_q, start_line_d;
	logic [NW-1:0]      count_q, count_d;
	logic               kw_alive_q, kw_alive_d;
	dlx_pkg::kw_cand_t  kw_cand_q, kw_cand_d;
	logic [2:0]         kw_pos_q, kw_pos_d;

	logic [LW-1:0] line_inc;
	logic [NW-1:0] count_inc;
	dlx_pkg::token_kind_t id_kind;

	// pending token (a) and the token of the byte itself or EOF (b)
	logic                 a_v, b_v, run_idle;
	dlx_pkg::token_kind_t a_kind, b_kind;
	logic [LW-1:0]        a_line, b_line;
	logic [NW-1:0]        a_len, b_len;

	// token queue
	dlx_pkg::token_kind_t kind_mem [dlx_pkg::FIFO_DEPTH];
	logic [LW-1:0]        line_mem [dlx_pkg::FIFO_DEPTH];
	logic [NW-1:0]        len_mem  [dlx_pkg::FIFO_DEPTH];
	logic                 last_mem [dlx_pkg::FIFO_DEPTH];
	logic [dlx_pkg::PTR_BITS-1:0] wr_q, rd_q, wr_next;
	logic [dlx_pkg::CNT_BITS-1:0] fill_q;
	logic [1:0]                   push_n;
	logic                         pop;

	assign take     = valid_s1 && (fill_q <= dlx_pkg::CNT_BITS'(dlx_pkg::FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			end_s1  <= is_end;
		end
	end

	assign line_inc  = (cur_line_q < LINE_MAX) ? cur_line_q + LW'(1) : cur_line_q;
	assign count_inc = (count_q < LEN_MAX) ? count_q + NW'(1) : count_q;
	assign id_kind   = (kw_alive_q && (kw_pos_q == dlx_pkg::kw_len(kw_cand_q)))
		? dlx_pkg::kw_token(kw_cand_q) : dlx_pkg::TK_ID;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= dlx_pkg::MODE_IDLE;
			cur_line_q   <= LW'(1);
			start_line_q <= LW'(1);
			count_q      <= '0;
			kw_alive_q   <= 1'b1;
			kw_cand_q    <= dlx_pkg::KW_SCHEMES;
			kw_pos_q     <= '0;
		end else if (take) begin
			mode_q       <= mode_d;
			cur_line_q   <= cur_line_d;
			start_line_q <= start_line_d;
			count_q      <= count_d;
			kw_alive_q   <= kw_alive_d;
			kw_cand_q    <= kw_cand_d;
			kw_pos_q     <= kw_pos_d;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		cur_line_d   = cur_line_q;
		start_line_d = start_line_q;
		count_d      = count_q;
		kw_alive_d   = kw_alive_q;
		kw_cand_d    = kw_cand_q;
		kw_pos_d     = kw_pos_q;
		a_v          = 1'b0;
		a_kind       = dlx_pkg::TK_UNDEFINED;
		a_line       = start_line_q;
		a_len        = count_q;
		b_v          = 1'b0;
		b_kind       = dlx_pkg::TK_UNDEFINED;
		b_line       = cur_line_q;
		b_len        = NW'(1);
		run_idle     = 1'b0;

		if (end_s1) begin
			unique case (mode_q)
				dlx_pkg::MODE_IDLE: ;
				dlx_pkg::MODE_COLON: begin
					a_v    = 1'b1;
					a_kind = dlx_pkg::TK_COLON;
				end
				dlx_pkg::MODE_ID: begin
					a_v    = 1'b1;
					a_kind = id_kind;
				end
				dlx_pkg::MODE_STR: begin
					a_v    = 1'b1;
					a_kind = dlx_pkg::TK_UNDEFINED;
				end
				dlx_pkg::MODE_STRQ: begin
					a_v    = 1'b1;
					a_kind = dlx_pkg::TK_STRING;
				end
				dlx_pkg::MODE_HASH, dlx_pkg::MODE_LINE: begin
					a_v    = 1'b1;
					a_kind = dlx_pkg::TK_COMMENT;
				end
				dlx_pkg::MODE_BLOCK, dlx_pkg::MODE_BAR: begin
					a_v    = 1'b1;
					a_kind = dlx_pkg::TK_UNDEFINED;
				end
				default: ;
			endcase
			b_v          = 1'b1;
			b_kind       = dlx_pkg::TK_EOF;
			b_len        = '0;
			mode_d       = dlx_pkg::MODE_IDLE;
			cur_line_d   = LW'(1);
			start_line_d = LW'(1);
			count_d      = '0;
			kw_alive_d   = 1'b1;
			kw_cand_d    = dlx_pkg::KW_SCHEMES;
			kw_pos_d     = '0;
		end else begin
			unique case (mode_q)
				dlx_pkg::MODE_IDLE: run_idle = 1'b1;
				dlx_pkg::MODE_COLON: begin
					if (byte_s1 == dlx_pkg::CH_DASH) begin
						a_v    = 1'b1;
						a_kind = dlx_pkg::TK_COLON_DASH;
						a_len  = NW'(2);
						mode_d = dlx_pkg::MODE_IDLE;
					end else begin
						a_v      = 1'b1;
						a_kind   = dlx_pkg::TK_COLON;
						run_idle = 1'b1;
					end
				end
				dlx_pkg::MODE_ID: begin
					if (dlx_pkg::is_idchar(byte_s1)) begin
						count_d = count_inc;
						if (kw_alive_q && (kw_pos_q < dlx_pkg::kw_len(kw_cand_q)) &&
						    (dlx_pkg::kw_char(kw_cand_q, kw_pos_q) == byte_s1)) begin
							kw_pos_d = kw_pos_q + 3'd1;
						end else begin
							kw_alive_d = 1'b0;
							kw_cand_d  = dlx_pkg::KW_SCHEMES;
							kw_pos_d   = '0;
						end
					end else begin
						a_v      = 1'b1;
						a_kind   = id_kind;
						run_idle = 1'b1;
					end
				end
				dlx_pkg::MODE_STR: begin
					count_d = count_inc;
					if (byte_s1 == dlx_pkg::CH_LF) cur_line_d = line_inc;
					if (byte_s1 == dlx_pkg::CH_QUOTE) mode_d = dlx_pkg::MODE_STRQ;
				end
				dlx_pkg::MODE_STRQ: begin
					// doubled quote stays inside the string
					if (byte_s1 == dlx_pkg::CH_QUOTE) begin
						count_d = count_inc;
						mode_d  = dlx_pkg::MODE_STR;
					end else begin
						a_v      = 1'b1;
						a_kind   = dlx_pkg::TK_STRING;
						run_idle = 1'b1;
					end
				end
				dlx_pkg::MODE_HASH: begin
					if (byte_s1 == dlx_pkg::CH_BAR) begin
						count_d = count_inc;
						mode_d  = dlx_pkg::MODE_BLOCK;
					end else if (byte_s1 == dlx_pkg::CH_LF) begin
						a_v      = 1'b1;
						a_kind   = dlx_pkg::TK_COMMENT;
						run_idle = 1'b1;
					end else begin
						count_d = count_inc;
						mode_d  = dlx_pkg::MODE_LINE;
					end
				end
				dlx_pkg::MODE_LINE: begin
					if (byte_s1 == dlx_pkg::CH_LF) begin
						a_v      = 1'b1;
						a_kind   = dlx_pkg::TK_COMMENT;
						run_idle = 1'b1;
					end else begin
						count_d = count_inc;
					end
				end
				dlx_pkg::MODE_BLOCK: begin
					count_d = count_inc;
					if (byte_s1 == dlx_pkg::CH_LF) cur_line_d = line_inc;
					if (byte_s1 == dlx_pkg::CH_BAR) mode_d = dlx_pkg::MODE_BAR;
				end
				dlx_pkg::MODE_BAR: begin
					count_d = count_inc;
					if (byte_s1 == dlx_pkg::CH_HASH) begin
						a_v    = 1'b1;
						a_kind = dlx_pkg::TK_COMMENT;
						a_len  = count_inc;
						mode_d = dlx_pkg::MODE_IDLE;
					end else if (byte_s1 != dlx_pkg::CH_BAR) begin
						if (byte_s1 == dlx_pkg::CH_LF) cur_line_d = line_inc;
						mode_d = dlx_pkg::MODE_BLOCK;
					end
				end
				default: run_idle = 1'b1;
			endcase

			// byte lexed afresh between tokens; no line bump precedes it in this beat
			if (run_idle) begin
				mode_d = dlx_pkg::MODE_IDLE;
				unique case (byte_s1)
					dlx_pkg::CH_COMMA: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_COMMA;
					end
					dlx_pkg::CH_PERIOD: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_PERIOD;
					end
					dlx_pkg::CH_QMARK: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_Q_MARK;
					end
					dlx_pkg::CH_LPAREN: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_LPAREN;
					end
					dlx_pkg::CH_RPAREN: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_RPAREN;
					end
					dlx_pkg::CH_STAR: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_MULTIPLY;
					end
					dlx_pkg::CH_PLUS: begin
						b_v    = 1'b1;
						b_kind = dlx_pkg::TK_ADD;
					end
					dlx_pkg::CH_SPACE, dlx_pkg::CH_CR: ;
					dlx_pkg::CH_LF: cur_line_d = line_inc;
					dlx_pkg::CH_COLON: begin
						mode_d       = dlx_pkg::MODE_COLON;
						start_line_d = cur_line_q;
						count_d      = NW'(1);
					end
					dlx_pkg::CH_QUOTE: begin
						mode_d       = dlx_pkg::MODE_STR;
						start_line_d = cur_line_q;
						count_d      = NW'(1);
					end
					dlx_pkg::CH_HASH: begin
						mode_d       = dlx_pkg::MODE_HASH;
						start_line_d = cur_line_q;
						count_d      = NW'(1);
					end
					default: begin
						if (dlx_pkg::is_alpha(byte_s1)) begin
							mode_d       = dlx_pkg::MODE_ID;
							start_line_d = cur_line_q;
							count_d      = NW'(1);
							kw_cand_d    = dlx_pkg::KW_SCHEMES;
							kw_pos_d     = 3'd1;
							kw_alive_d   = 1'b1;
							priority if (byte_s1 == dlx_pkg::CH_UC_S) begin
								kw_cand_d = dlx_pkg::KW_SCHEMES;
							end else if (byte_s1 == dlx_pkg::CH_UC_F) begin
								kw_cand_d = dlx_pkg::KW_FACTS;
							end else if (byte_s1 == dlx_pkg::CH_UC_R) begin
								kw_cand_d = dlx_pkg::KW_RULES;
							end else if (byte_s1 == dlx_pkg::CH_UC_Q) begin
								kw_cand_d = dlx_pkg::KW_QUERIES;
							end else begin
								kw_alive_d = 1'b0;
								kw_pos_d   = '0;
							end
						end else begin
							b_v    = 1'b1;
							b_kind = dlx_pkg::TK_UNDEFINED;
						end
					end
				endcase
			end
		end
	end

	// token queue: up to two writes a beat, one read a cycle
	assign push_n  = take ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
	assign pop     = out_valid && !out_stall;
	assign wr_next = wr_q + dlx_pkg::PTR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + dlx_pkg::PTR_BITS'(push_n);
			if (pop) rd_q <= rd_q + dlx_pkg::PTR_BITS'(1);
			fill_q <= fill_q + dlx_pkg::CNT_BITS'(push_n) - dlx_pkg::CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			kind_mem[wr_q] <= a_v ? a_kind : b_kind;
			line_mem[wr_q] <= a_v ? a_line : b_line;
			len_mem[wr_q]  <= a_v ? a_len : b_len;
			last_mem[wr_q] <= !(a_v && b_v);
		end
		if (push_n == 2'd2) begin
			kind_mem[wr_next] <= b_kind;
			line_mem[wr_next] <= b_line;
			len_mem[wr_next]  <= b_len;
			last_mem[wr_next] <= 1'b1;
		end
	end

	assign out_valid    = (fill_q != '0);
	assign token_kind   = kind_mem[rd_q];
	assign token_line   = dlx_pkg::OUT_BITS'(line_mem[rd_q]);
	assign token_length = dlx_pkg::OUT_BITS'(len_mem[rd_q]);
	assign last         = last_mem[rd_q];

endmodule

`default_nettype wire

// File: rtl/core/dlx_checker.sv
// Port-level checker for the Datalog lexer, bound to datalog_lexer_top.
// Depends on dlx_pkg and datalog_lexer_top_macros.svh.
`default_nettype none

`include "datalog_lexer_top_macros.svh"

module dlx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [4:0]  token_kind,
	input wire logic [15:0] token_line,
	input wire logic [15:0] token_length,
	input wire logic        last
);

	// held beat keeps its payload
	`DLX_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(token_line) && $stable(token_length) && $stable(last), "output beat changed while stalled")

	// the second token of a pair is queued with the first, so it follows at once
	`DLX_ASSERT_NEXT(a_pair, out_valid && !out_stall && !last, out_valid, "second token of a pair missing")

	`DLX_ASSERT_NOW(a_eof, out_valid && (token_kind == dlx_pkg::TK_EOF), last && (token_length == 16'd0), "EOF not final or has length")

	`DLX_ASSERT_NOW(a_cdash, out_valid && (token_kind == dlx_pkg::TK_COLON_DASH), last && (token_length == 16'd2), "colon-dash malformed")

endmodule

bind datalog_lexer_top dlx_checker u_dlx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.token_kind   (token_kind),
	.token_line   (token_line),
	.token_length (token_length),
	.last         (last)
);

`default_nettype wire

// File: tb/sv/datalog_lexer_top_tb.sv
`timescale 1ns / 1ps
// Testbench for datalog_lexer_top: byte and end-mark beats go in with random idling,
// a scoreboard predicts every token beat and checks the outputs field by field.
// Depends on dlx_pkg and datalog_lexer_top.

typedef struct {
	dlx_pkg::token_kind_t kind;
	logic [15:0]          line;
	logic [15:0]          len;
	logic                 last;
} lex_token_t;

class token_scoreboard;
	// line and length saturate here at the default port widths
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	lex_token_t         expected_q[$];
	int unsigned        fails;
	string              kw_words[4];
	dlx_pkg::lex_mode_t mode;
	logic [15:0]        cur_line;
	logic [15:0]        tok_line;
	logic [15:0]        tok_len;
	logic               kw_alive;
	dlx_pkg::kw_cand_t  kw_cand;
	logic [2:0]         kw_pos;

	function new();
		kw_words[0] = "Schemes";
		kw_words[1] = "Facts";
		kw_words[2] = "Rules";
		kw_words[3] = "Queries";
		fails = 0;
		clear_state();
	endfunction

	function void clear_state();
		mode     = dlx_pkg::MODE_IDLE;
		cur_line = 16'd1;
		tok_line = 16'd1;
		tok_len  = 16'd0;
		kw_alive = 1'b1;
		kw_cand  = dlx_pkg::KW_SCHEMES;
		kw_pos   = 3'd0;
	endfunction

	function void push_token(dlx_pkg::token_kind_t k, logic [15:0] line, logic [15:0] len);
		lex_token_t t;
		t.kind = k;
		t.line = line;
		t.len  = len;
		t.last = 1'b0;
		expected_q = {expected_q, t};
	endfunction

	function void open_token(dlx_pkg::lex_mode_t m);
		mode     = m;
		tok_line = cur_line;
		tok_len  = 16'd1;
	endfunction

	function void grow();
		if (tok_len != COUNT_MAX) tok_len++;
	endfunction

	function void next_line();
		if (cur_line != COUNT_MAX) cur_line++;
	endfunction

	function bit letter(logic [7:0] b);
		logic [7:0] l;
		l = b | dlx_pkg::CASE_BIT;
		return (l >= dlx_pkg::CH_LC_A) && (l <= dlx_pkg::CH_LC_Z);
	endfunction

	function void kw_first(logic [7:0] b);
		kw_alive = 1'b1;
		kw_pos   = 3'd1;
		case (b)
			dlx_pkg::CH_UC_S: kw_cand = dlx_pkg::KW_SCHEMES;
			dlx_pkg::CH_UC_F: kw_cand = dlx_pkg::KW_FACTS;
			dlx_pkg::CH_UC_R: kw_cand = dlx_pkg::KW_RULES;
			dlx_pkg::CH_UC_Q: kw_cand = dlx_pkg::KW_QUERIES;
			default:          kw_alive = 1'b0;
		endcase
	endfunction

	function void kw_next(logic [7:0] b);
		if (kw_alive && kw_pos < kw_words[int'(kw_cand)].len() &&
				kw_words[int'(kw_cand)][kw_pos] == b) begin
			kw_pos++;
		end else begin
			kw_alive = 1'b0;
		end
	endfunction

	function dlx_pkg::token_kind_t id_kind();
		if (kw_alive && kw_pos == kw_words[int'(kw_cand)].len())
			return dlx_pkg::token_kind_t'(dlx_pkg::TK_SCHEMES + kw_cand);
		return dlx_pkg::TK_ID;
	endfunction

	// byte seen between tokens, or re-lexed after closing the previous one
	function void lex_fresh(logic [7:0] b);
		mode = dlx_pkg::MODE_IDLE;
		case (b)
			dlx_pkg::CH_COMMA:  push_token(dlx_pkg::TK_COMMA, cur_line, 16'd1);
			dlx_pkg::CH_PERIOD: push_token(dlx_pkg::TK_PERIOD, cur_line, 16'd1);
			dlx_pkg::CH_QMARK:  push_token(dlx_pkg::TK_Q_MARK, cur_line, 16'd1);
			dlx_pkg::CH_LPAREN: push_token(dlx_pkg::TK_LPAREN, cur_line, 16'd1);
			dlx_pkg::CH_RPAREN: push_token(dlx_pkg::TK_RPAREN, cur_line, 16'd1);
			dlx_pkg::CH_STAR:   push_token(dlx_pkg::TK_MULTIPLY, cur_line, 16'd1);
			dlx_pkg::CH_PLUS:   push_token(dlx_pkg::TK_ADD, cur_line, 16'd1);
			dlx_pkg::CH_SPACE, dlx_pkg::CH_CR: ;
			dlx_pkg::CH_LF:     next_line();
			dlx_pkg::CH_COLON:  open_token(dlx_pkg::MODE_COLON);
			dlx_pkg::CH_QUOTE:  open_token(dlx_pkg::MODE_STR);
			dlx_pkg::CH_HASH:   open_token(dlx_pkg::MODE_HASH);
			default: begin
				if (letter(b)) begin
					open_token(dlx_pkg::MODE_ID);
					kw_first(b);
				end else begin
					push_token(dlx_pkg::TK_UNDEFINED, cur_line, 16'd1);
				end
			end
		endcase
	endfunction

	function void note_beat(logic [7:0] b, logic e);
		int unsigned before_n;
		before_n = expected_q.size();
		if (e) begin
			case (mode)
				dlx_pkg::MODE_COLON: push_token(dlx_pkg::TK_COLON, tok_line, tok_len);
				dlx_pkg::MODE_ID:    push_token(id_kind(), tok_line, tok_len);
				dlx_pkg::MODE_STRQ:  push_token(dlx_pkg::TK_STRING, tok_line, tok_len);
				dlx_pkg::MODE_HASH, dlx_pkg::MODE_LINE:
					push_token(dlx_pkg::TK_COMMENT, tok_line, tok_len);
				dlx_pkg::MODE_STR, dlx_pkg::MODE_BLOCK, dlx_pkg::MODE_BAR:
					push_token(dlx_pkg::TK_UNDEFINED, tok_line, tok_len);
				default: ;
			endcase
			push_token(dlx_pkg::TK_EOF, cur_line, 16'd0);
			clear_state();
		end else begin
			case (mode)
				dlx_pkg::MODE_COLON: begin
					if (b == dlx_pkg::CH_DASH) begin
						push_token(dlx_pkg::TK_COLON_DASH, tok_line, 16'd2);
						mode = dlx_pkg::MODE_IDLE;
					end else begin
						push_token(dlx_pkg::TK_COLON, tok_line, tok_len);
						lex_fresh(b);
					end
				end
				dlx_pkg::MODE_ID: begin
					if (letter(b) || (b >= dlx_pkg::CH_DIG_0 && b <= dlx_pkg::CH_DIG_9) ||
							b == dlx_pkg::CH_UNDER) begin
						grow();
						kw_next(b);
					end else begin
						push_token(id_kind(), tok_line, tok_len);
						lex_fresh(b);
					end
				end
				dlx_pkg::MODE_STR: begin
					grow();
					if (b == dlx_pkg::CH_LF) next_line();
					if (b == dlx_pkg::CH_QUOTE) mode = dlx_pkg::MODE_STRQ;
				end
				dlx_pkg::MODE_STRQ: begin
					// doubled quote stays inside the string
					if (b == dlx_pkg::CH_QUOTE) begin
						grow();
						mode = dlx_pkg::MODE_STR;
					end else begin
						push_token(dlx_pkg::TK_STRING, tok_line, tok_len);
						lex_fresh(b);
					end
				end
				dlx_pkg::MODE_HASH: begin
					if (b == dlx_pkg::CH_BAR) begin
						grow();
						mode = dlx_pkg::MODE_BLOCK;
					end else if (b == dlx_pkg::CH_LF) begin
						push_token(dlx_pkg::TK_COMMENT, tok_line, tok_len);
						lex_fresh(b);
					end else begin
						grow();
						mode = dlx_pkg::MODE_LINE;
					end
				end
				dlx_pkg::MODE_LINE: begin
					if (b == dlx_pkg::CH_LF) begin
						push_token(dlx_pkg::TK_COMMENT, tok_line, tok_len);
						lex_fresh(b);
					end else begin
						grow();
					end
				end
				dlx_pkg::MODE_BLOCK: begin
					grow();
					if (b == dlx_pkg::CH_LF) next_line();
					if (b == dlx_pkg::CH_BAR) mode = dlx_pkg::MODE_BAR;
				end
				dlx_pkg::MODE_BAR: begin
					grow();
					if (b == dlx_pkg::CH_HASH) begin
						push_token(dlx_pkg::TK_COMMENT, tok_line, tok_len);
						mode = dlx_pkg::MODE_IDLE;
					end else if (b != dlx_pkg::CH_BAR) begin
						if (b == dlx_pkg::CH_LF) next_line();
						mode = dlx_pkg::MODE_BLOCK;
					end
				end
				default: lex_fresh(b);
			endcase
		end
		if (expected_q.size() > before_n) expected_q[expected_q.size() - 1].last = 1'b1;
	endfunction

	function void check_token(logic [4:0] kind, logic [15:0] line, logic [15:0] len,
			logic lst);
		lex_token_t want;
		if (expected_q.size() == 0) begin
			$error("token beat with nothing expected: kind %0d, line %0d, length %0d",
				kind, line, len);
			fails++;
			return;
		end
		want = expected_q.pop_front();
		if (kind !== want.kind) begin
			$error("token_kind: expected %0d, got %0d", want.kind, kind);
			fails++;
		end
		if (line !== want.line) begin
			$error("token_line: expected %0d, got %0d", want.line, line);
			fails++;
		end
		if (len !== want.len) begin
			$error("token_length: expected %0d, got %0d", want.len, len);
			fails++;
		end
		if (lst !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, lst);
			fails++;
		end
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction
endclass

module datalog_lexer_top_tb;
	localparam int          SRC_BEATS    = 950;
	localparam int          CALM_BEATS   = 150;     // tail of the run without idling
	localparam int          DRAIN_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_byte   = 8'h00;
	logic        is_end    = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [4:0]  token_kind;
	logic [15:0] token_line;
	logic [15:0] token_length;
	logic        last;

	token_scoreboard tokens;
	logic [7:0]      text_q[$];
	bit              src_idle_en = 1'b0;
	bit              snk_idle_en = 1'b0;
	logic [3:0]      stall_left  = 4'd0;
	int unsigned     cycle_cnt   = 0;
	int unsigned     random_beats;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	datalog_lexer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.is_end       (is_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_length (token_length),
		.last         (last)
	);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tokens.check_token(token_kind, token_line, token_length, last);
	end

	// sink back-pressure in random bursts
	always @(posedge clk) begin
		if (!snk_idle_en) begin
			out_stall  <= 1'b0;
			stall_left <= 4'd0;
		end else if (stall_left != 4'd0) begin
			stall_left <= stall_left - 4'd1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= 4'($urandom_range(0, 15));
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("** datalog_lexer_top: FAILED **");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic e);
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		is_end   <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tokens.note_beat(b, e);
	endtask

	task automatic finish_stream(input logic [7:0] junk);
		foreach (text_q[i]) send_beat(text_q[i], 1'b0);
		send_beat(junk, 1'b1);
		text_q.delete();
	endtask

	function automatic void add_byte(input logic [7:0] c);
		text_q = {text_q, c};
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_letter();
		logic [7:0] c;
		c = dlx_pkg::CH_LC_A + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 1) == 1) c = c & ~dlx_pkg::CASE_BIT;
		return c;
	endfunction

	// one lexeme of Datalog-like text; closed = 0 leaves strings and comments open
	task automatic add_piece(input int unsigned r, input bit closed);
		logic [7:0] c;
		logic [7:0] prev;
		string      w;
		if (r < 22) begin
			case ($urandom_range(0, 8))
				0:       add_byte(dlx_pkg::CH_COMMA);
				1:       add_byte(dlx_pkg::CH_PERIOD);
				2:       add_byte(dlx_pkg::CH_QMARK);
				3:       add_byte(dlx_pkg::CH_LPAREN);
				4:       add_byte(dlx_pkg::CH_RPAREN);
				5:       add_byte(dlx_pkg::CH_STAR);
				6:       add_byte(dlx_pkg::CH_PLUS);
				7:       add_byte(dlx_pkg::CH_COLON);
				default: push_str(":-");
			endcase
		end else if (r < 38) begin
			case ($urandom_range(0, 3))
				0:       w = "Schemes";
				1:       w = "Facts";
				2:       w = "Rules";
				default: w = "Queries";
			endcase
			// near misses: short, long, wrong case, wrong letter
			if (r >= 32) begin
				case ($urandom_range(0, 3))
					0:       w = w.substr(0, w.len() - 2);
					1:       w = {w, "_"};
					2:       w.putc(0, w[0] | dlx_pkg::CASE_BIT);
					default: w.putc(2, "Z");
				endcase
			end
			push_str(w);
			if ($urandom_range(0, 9) < 7) add_byte(dlx_pkg::CH_SPACE);
		end else if (r < 52) begin
			c = pick_letter();
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0:       c = dlx_pkg::CH_UC_S;
					1:       c = dlx_pkg::CH_UC_F;
					2:       c = dlx_pkg::CH_UC_R;
					default: c = dlx_pkg::CH_UC_Q;
				endcase
			end
			add_byte(c);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 5))
					0:       c = dlx_pkg::CH_DIG_0 + 8'($urandom_range(0, 9));
					1:       c = dlx_pkg::CH_UNDER;
					default: c = pick_letter();
				endcase
				add_byte(c);
			end
			if ($urandom_range(0, 9) < 7) add_byte(dlx_pkg::CH_SPACE);
		end else if (r < 62) begin
			add_byte(dlx_pkg::CH_QUOTE);
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 9))
					0: push_str("''");
					1: add_byte(dlx_pkg::CH_LF);
					2: add_byte(8'($urandom_range(128, 255)));
					default: begin
						c = 8'($urandom_range(32, 126));
						if (c == dlx_pkg::CH_QUOTE) c = dlx_pkg::CH_SPACE;
						add_byte(c);
					end
				endcase
			end
			if (closed) add_byte(dlx_pkg::CH_QUOTE);
		end else if (r < 69) begin
			add_byte(dlx_pkg::CH_HASH);
			prev = dlx_pkg::CH_HASH;
			repeat ($urandom_range(0, 10)) begin
				c = 8'($urandom_range(32, 255));
				if (prev == dlx_pkg::CH_HASH && c == dlx_pkg::CH_BAR) c = dlx_pkg::CH_SPACE;
				add_byte(c);
				prev = c;
			end
			if (closed) add_byte(dlx_pkg::CH_LF);
		end else if (r < 77) begin
			push_str("#|");
			prev = 8'h00;
			repeat ($urandom_range(0, 10)) begin
				case ($urandom_range(0, 9))
					0, 1:    c = dlx_pkg::CH_BAR;
					2:       c = dlx_pkg::CH_HASH;
					3:       c = dlx_pkg::CH_LF;
					default: c = 8'($urandom_range(0, 255));
				endcase
				if (prev == dlx_pkg::CH_BAR && c == dlx_pkg::CH_HASH) c = dlx_pkg::CH_SPACE;
				add_byte(c);
				prev = c;
			end
			if (closed) push_str("|#");
		end else if (r < 93) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 3))
					0:       add_byte(dlx_pkg::CH_SPACE);
					1:       add_byte(dlx_pkg::CH_CR);
					default: add_byte(dlx_pkg::CH_LF);
				endcase
			end
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		tokens = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keyword, colon-dash, escaped quote, open string at the end mark
		src_idle_en = 1'b1;
		snk_idle_en <= 1'b1;
		push_str("Queries:-'x''y'");
		finish_stream(8'hFF);
		push_str("#|\n|");                  // block comment cut off by the end mark
		finish_stream(8'h00);
		push_str("#");
		finish_stream(8'h55);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h09);
		add_byte(dlx_pkg::CH_UC_S);
		finish_stream(8'hAA);
		push_str("'");
		finish_stream(8'hFF);
		push_str(":");
		finish_stream(8'h00);
		finish_stream(8'hFF);               // empty stream, EOF only

		random_beats = 0;
		while (random_beats < SRC_BEATS) begin
			if (random_beats + CALM_BEATS >= SRC_BEATS) begin
				src_idle_en = 1'b0;
				snk_idle_en <= 1'b0;
			end else begin
				src_idle_en = ($urandom_range(0, 3) != 0);
				snk_idle_en <= ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 9) != 0)
				repeat ($urandom_range(1, 30)) add_piece($urandom_range(0, 99), 1'b1);
			if ($urandom_range(0, 6) == 0) add_piece($urandom_range(52, 76), 1'b0);
			random_beats += text_q.size() + 1;
			finish_stream(8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;

		while (tokens.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tokens.fails == 0) begin
			$display("** datalog_lexer_top: PASSED **");
		end else begin
			$display("** datalog_lexer_top: FAILED **");
		end
		$finish;
	end
endmodule
